### src/g2j_pkg.sv
// Shared types, constants and lookup functions for the Gregorian to Jalali date unit.
`default_nettype none
package g2j_pkg;

    typedef struct packed {
        logic [13:0] gregorian_year;
        logic [3:0]  gregorian_month;
        logic [4:0]  gregorian_day;
        logic [2:0]  gregorian_weekday;
    } greg_date_t;

    typedef struct packed {
        logic [13:0] jalali_year;
        logic [3:0]  jalali_month;
        logic [4:0]  jalali_day;
        logic [8:0]  jalali_day_of_year;
        logic [2:0]  jalali_weekday;
    } jal_date_t;

    // Day count since 1 Farvardin 979 with the weekday already moved to Saturday base
    typedef struct packed {
        logic [22:0] cnt;
        logic [2:0]  weekday;
    } day_count_t;

    // Jalali year and zero-based day of that year
    typedef struct packed {
        logic [13:0] year;
        logic [8:0]  doy;
        logic [2:0]  weekday;
    } year_day_t;

    localparam logic [13:0] YEAR_MIN        = 14'd1601;
    localparam logic [13:0] EPOCH_YEAR      = 14'd1600;
    localparam logic [3:0]  MONTH_FIRST     = 4'd1;
    localparam logic [3:0]  MONTH_LAST      = 4'd12;
    localparam logic [22:0] DAYS_PER_YEAR   = 23'd365;
    localparam logic [22:0] EPOCH_OFFSET    = 23'd79;
    localparam logic [22:0] CYCLE_DAYS      = 23'd12053;
    localparam logic [13:0] CYCLE_YEARS     = 14'd33;
    localparam logic [13:0] GROUP_DAYS      = 14'd1461;
    localparam logic [13:0] JALALI_BASE     = 14'd979;
    localparam logic [10:0] JAL_YEAR_DAYS   = 11'd365;
    localparam logic [13:0] CENTURY_YEARS   = 14'd100;

    // floor(x / 100) as (x * DIV100_MUL) >> DIV100_SHIFT, exact for x below 2^21 / 100
    localparam int          DIV100_SHIFT    = 21;
    localparam logic [14:0] DIV100_MUL      = 15'(((64'd1 << DIV100_SHIFT) + 64'd99) / 64'd100);

    // floor(cnt / 12053) by reciprocal, exact for cnt below 2^37 / 12053
    localparam int          DIVCYC_SHIFT    = 37;
    localparam logic [23:0] DIVCYC_MUL      =
        24'(((64'd1 << DIVCYC_SHIFT) + 64'd12052) / 64'd12053);

    // Days before the start of a Gregorian month in a common year, month index from 0
    function automatic logic [8:0] greg_month_start(input logic [3:0] m0);
        logic [8:0] days;
        case (m0)
            4'd0:    days = 9'd0;
            4'd1:    days = 9'd31;
            4'd2:    days = 9'd59;
            4'd3:    days = 9'd90;
            4'd4:    days = 9'd120;
            4'd5:    days = 9'd151;
            4'd6:    days = 9'd181;
            4'd7:    days = 9'd212;
            4'd8:    days = 9'd243;
            4'd9:    days = 9'd273;
            4'd10:   days = 9'd304;
            default: days = 9'd334;
        endcase
        return days;
    endfunction

    // Days before the start of a Jalali month, month index from 0
    function automatic logic [8:0] jal_month_start(input logic [3:0] m0);
        logic [8:0] days;
        case (m0)
            4'd0:    days = 9'd0;
            4'd1:    days = 9'd31;
            4'd2:    days = 9'd62;
            4'd3:    days = 9'd93;
            4'd4:    days = 9'd124;
            4'd5:    days = 9'd155;
            4'd6:    days = 9'd186;
            4'd7:    days = 9'd216;
            4'd8:    days = 9'd246;
            4'd9:    days = 9'd276;
            4'd10:   days = 9'd306;
            default: days = 9'd336;
        endcase
        return days;
    endfunction

endpackage
`default_nettype wire

### src/g2j_chan_if.sv
// Valid/ready channel interface with a typed payload.
`default_nettype none
interface g2j_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/g2j_day_count.sv
// Input register and day count since 1 Farvardin 979 (three pipeline stages).
`default_nettype none
module g2j_day_count (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                date_valid,
    output logic                date_ready,
    input  g2j_pkg::greg_date_t date,
    output logic                count_valid,
    input  logic                count_ready,
    output g2j_pkg::day_count_t count
);
    import g2j_pkg::*;

    // stage 0: raw request
    logic        vld0_reg;
    greg_date_t  date_reg;
    // stage 1: clamped year offset and century count
    logic        vld1_reg;
    logic [13:0] gy_reg;
    logic [7:0]  c100_reg;
    logic [3:0]  m0_reg;
    logic [4:0]  day_reg;
    logic [2:0]  wd_reg;
    // stage 2: day count
    logic        vld2_reg;
    day_count_t  count_reg;

    logic        ld0, ld1, ld2;

    logic [13:0] year_c;
    logic [3:0]  month_c;
    logic [13:0] gy_next;
    logic [13:0] gy_up;
    logic [28:0] c100_prod;
    logic [3:0]  m0_next;
    logic [2:0]  wd_next;

    logic [13:0] gy_q4;
    logic [7:0]  c100_q4;
    logic [11:0] c4;
    logic [5:0]  c400;
    logic        century;
    logic        leap;
    logic [22:0] cnt_next;

    assign ld2 = !vld2_reg || count_ready;
    assign ld1 = !vld1_reg || ld2;
    assign ld0 = !vld0_reg || ld1;
    assign date_ready  = ld0;
    assign count_valid = vld2_reg;
    assign count       = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else
        begin
            if (ld0)
            begin
                vld0_reg <= date_valid;
            end
            if (ld1)
            begin
                vld1_reg <= vld0_reg;
            end
            if (ld2)
            begin
                vld2_reg <= vld1_reg;
            end
        end
    end

    // stage 1: clamp, year offset, ceil(gy / 100) by reciprocal
    always_comb
    begin
        year_c = (date_reg.gregorian_year < YEAR_MIN) ? YEAR_MIN : date_reg.gregorian_year;
        if (date_reg.gregorian_month < MONTH_FIRST)
        begin
            month_c = MONTH_FIRST;
        end
        else if (date_reg.gregorian_month > MONTH_LAST)
        begin
            month_c = MONTH_LAST;
        end
        else
        begin
            month_c = date_reg.gregorian_month;
        end
        gy_next   = year_c - EPOCH_YEAR;
        m0_next   = month_c - MONTH_FIRST;
        gy_up     = gy_next + 14'd99;
        c100_prod = 29'(gy_up) * 29'(DIV100_MUL);
        // shift weekday to Saturday base, mod 7
        case (date_reg.gregorian_weekday)
            3'd6:    wd_next = 3'd0;
            3'd7:    wd_next = 3'd1;
            default: wd_next = date_reg.gregorian_weekday + 3'd1;
        endcase
    end

    // stage 2: leap days and day count
    always_comb
    begin
        gy_q4   = gy_reg + 14'd3;
        c100_q4 = c100_reg + 8'd3;
        c4      = gy_q4[13:2];
        c400    = c100_q4[7:2];
        // ceil(gy / 100) times 100 hits gy only on a century year
        century = ((14'(c100_reg) * CENTURY_YEARS) == gy_reg);
        leap    = ((gy_reg[1:0] == 2'd0) && !century) || (century && (c100_reg[1:0] == 2'd0));
        cnt_next = 23'(gy_reg) * DAYS_PER_YEAR
                 + 23'(c4)
                 - 23'(c100_reg)
                 + 23'(c400)
                 + 23'(greg_month_start(m0_reg))
                 + 23'((m0_reg > 4'd1) && leap)
                 + 23'(day_reg)
                 - 23'd1
                 - EPOCH_OFFSET;
    end

    always_ff @(posedge clk)
    begin
        if (ld0 && date_valid)
        begin
            date_reg <= date;
        end
        if (ld1 && vld0_reg)
        begin
            gy_reg   <= gy_next;
            c100_reg <= c100_prod[28:21];
            m0_reg   <= m0_next;
            day_reg  <= date_reg.gregorian_day;
            wd_reg   <= wd_next;
        end
        if (ld2 && vld1_reg)
        begin
            count_reg.cnt     <= cnt_next;
            count_reg.weekday <= wd_reg;
        end
    end

endmodule
`default_nettype wire

### src/g2j_cycle_split.sv
// Split of the day count into 33-year cycles, 4-year groups and years (three stages).
`default_nettype none
module g2j_cycle_split (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                count_valid,
    output logic                count_ready,
    input  g2j_pkg::day_count_t count,
    output logic                year_valid,
    input  logic                year_ready,
    output g2j_pkg::year_day_t  year_day
);
    import g2j_pkg::*;

    // stage 3: cycle count
    logic        vld3_reg;
    logic [8:0]  q33_reg;
    logic [22:0] cnt_reg;
    logic [2:0]  wd3_reg;
    // stage 4: day within cycle, year of cycle start
    logic        vld4_reg;
    logic [13:0] r33_reg;
    logic [13:0] base_reg;
    logic [2:0]  wd4_reg;
    // stage 5: Jalali year and day of year
    logic        vld5_reg;
    year_day_t   year_day_reg;

    logic        ld3, ld4, ld5;

    logic [46:0] q33_prod;
    logic [22:0] cyc_days;
    logic [13:0] r33_next;
    logic [13:0] base_next;

    logic [3:0]  q4;
    logic [13:0] r2_wide;
    logic [10:0] r2;
    logic [1:0]  yg;
    logic [10:0] doy_wide;
    logic [13:0] year_next;

    assign ld5 = !vld5_reg || year_ready;
    assign ld4 = !vld4_reg || ld5;
    assign ld3 = !vld3_reg || ld4;
    assign count_ready = ld3;
    assign year_valid  = vld5_reg;
    assign year_day    = year_day_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
        end
        else
        begin
            if (ld3)
            begin
                vld3_reg <= count_valid;
            end
            if (ld4)
            begin
                vld4_reg <= vld3_reg;
            end
            if (ld5)
            begin
                vld5_reg <= vld4_reg;
            end
        end
    end

    assign q33_prod = 47'(count.cnt) * 47'(DIVCYC_MUL);

    // stage 4: remainder within the cycle
    always_comb
    begin
        cyc_days  = 23'(q33_reg) * CYCLE_DAYS;
        r33_next  = 14'(cnt_reg - cyc_days);
        base_next = JALALI_BASE + 14'(q33_reg) * CYCLE_YEARS;
    end

    // stage 5: 4-year group by compares, then year within the group
    always_comb
    begin
        q4 = 4'd0;
        for (int k = 1; k <= 8; k++)
        begin
            if (r33_reg >= 14'(k) * GROUP_DAYS)
            begin
                q4 = q4 + 4'd1;
            end
        end
        r2_wide = r33_reg - 14'(q4) * GROUP_DAYS;
        r2      = r2_wide[10:0];
        // first year of a group is the long one
        if (r2 >= 11'd1096)
        begin
            yg = 2'd3;
        end
        else if (r2 >= 11'd731)
        begin
            yg = 2'd2;
        end
        else if (r2 >= 11'd366)
        begin
            yg = 2'd1;
        end
        else
        begin
            yg = 2'd0;
        end
        if (yg == 2'd0)
        begin
            doy_wide = r2;
        end
        else
        begin
            doy_wide = r2 - 11'd1 - 11'(yg) * JAL_YEAR_DAYS;
        end
        year_next = base_reg + {8'd0, q4, 2'd0} + 14'(yg);
    end

    always_ff @(posedge clk)
    begin
        if (ld3 && count_valid)
        begin
            q33_reg <= q33_prod[45:37];
            cnt_reg <= count.cnt;
            wd3_reg <= count.weekday;
        end
        if (ld4 && vld3_reg)
        begin
            r33_reg  <= r33_next;
            base_reg <= base_next;
            wd4_reg  <= wd3_reg;
        end
        if (ld5 && vld4_reg)
        begin
            year_day_reg.year    <= year_next;
            year_day_reg.doy     <= doy_wide[8:0];
            year_day_reg.weekday <= wd4_reg;
        end
    end

endmodule
`default_nettype wire

### src/g2j_month_walk.sv
// Month and day lookup from the day of year, feeding the result register.
`default_nettype none
module g2j_month_walk (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               year_valid,
    output logic               year_ready,
    input  g2j_pkg::year_day_t year_day,
    output logic               result_valid,
    input  logic               result_ready,
    output g2j_pkg::jal_date_t result
);
    import g2j_pkg::*;

    logic        vld6_reg;
    jal_date_t   result_reg;
    logic        ld6;

    logic [3:0]  midx;
    logic [8:0]  day_off;
    jal_date_t   result_next;

    assign ld6          = !vld6_reg || result_ready;
    assign year_ready   = ld6;
    assign result_valid = vld6_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld6_reg <= 1'b0;
        end
        else if (ld6)
        begin
            vld6_reg <= year_valid;
        end
    end

    // month starts rise monotonically, so the month index is the count of starts passed
    always_comb
    begin
        midx = 4'd0;
        for (int k = 1; k <= 11; k++)
        begin
            if (year_day.doy >= jal_month_start(4'(k)))
            begin
                midx = midx + 4'd1;
            end
        end
        day_off = year_day.doy - jal_month_start(midx);
        result_next.jalali_year        = year_day.year;
        result_next.jalali_month       = midx + 4'd1;
        result_next.jalali_day         = day_off[4:0] + 5'd1;
        result_next.jalali_day_of_year = year_day.doy + 9'd1;
        result_next.jalali_weekday     = year_day.weekday;
    end

    always_ff @(posedge clk)
    begin
        if (ld6 && year_valid)
        begin
            result_reg <= result_next;
        end
    end

endmodule
`default_nettype wire

### src/gregorian_to_jalali_date_unit.sv
// Top level: Gregorian to Jalali (Solar Hijri) date converter.
//
// Requests arrive on gdate (Gregorian year, month, day, Sunday-based weekday)
// and results leave on jdate (Jalali year, month, day, day of year and
// Saturday-based weekday). Both are valid/ready channels; a request moves at
// a clock edge with valid and ready high.
// Throughput is one request per cycle while jdate.ready stays high. A request
// passes through an input register, five pipeline registers and the result
// register; each register after the input one is fed by a few constant
// multiplies and adds or a small bank of constant compares.
// Each stage loads whenever it is empty or the stage after it moves, so a
// stalled receiver holds the result register and the pipeline keeps taking
// requests until its seven stages are full; only then does gdate.ready fall.
// Reset clears all stage valid flags; the block is ready in the first cycle
// after reset is released. Out-of-range months are clamped, years below 1601
// are taken as 1601 and day numbers are not checked.
`default_nettype none
module gregorian_to_jalali_date_unit (
    input  logic            clk,
    input  logic            rst_n,
    g2j_chan_if.sink        gdate,
    g2j_chan_if.source      jdate
);
    import g2j_pkg::*;

    logic       count_valid;
    logic       count_ready;
    day_count_t count;
    logic       year_valid;
    logic       year_ready;
    year_day_t  year_day;

    g2j_day_count u_day_count (
        .clk         (clk),
        .rst_n       (rst_n),
        .date_valid  (gdate.valid),
        .date_ready  (gdate.ready),
        .date        (gdate.data),
        .count_valid (count_valid),
        .count_ready (count_ready),
        .count       (count)
    );

    g2j_cycle_split u_cycle_split (
        .clk         (clk),
        .rst_n       (rst_n),
        .count_valid (count_valid),
        .count_ready (count_ready),
        .count       (count),
        .year_valid  (year_valid),
        .year_ready  (year_ready),
        .year_day    (year_day)
    );

    g2j_month_walk u_month_walk (
        .clk          (clk),
        .rst_n        (rst_n),
        .year_valid   (year_valid),
        .year_ready   (year_ready),
        .year_day     (year_day),
        .result_valid (jdate.valid),
        .result_ready (jdate.ready),
        .result       (jdate.data)
    );

    // back-pressure reaches the input only through a full pipeline
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        !gdate.ready |-> jdate.valid)
        else $error("input stalled with no result pending");

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        jdate.valid |-> (jdate.data.jalali_month >= MONTH_FIRST)
                     && (jdate.data.jalali_month <= MONTH_LAST))
        else $error("jalali month out of range");

    a_day_of_year: assert property (@(posedge clk) disable iff (!rst_n)
        jdate.valid |-> jdate.data.jalali_day_of_year
            == jal_month_start(jdate.data.jalali_month - 4'd1) + 9'(jdate.data.jalali_day))
        else $error("day of year disagrees with month and day");

    a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
        jdate.valid |-> jdate.data.jalali_weekday != 3'd7)
        else $error("weekday out of range");

endmodule
`default_nettype wire
